// File: hw/rtl/video_frame_slice_packetizer_top_assert.svh
// Assertion macros for the video frame slice packetizer checker.
// Depends on a clk and an active-low rst_n being visible where the macros are used.
`ifndef VIDEO_FRAME_SLICE_PACKETIZER_TOP_ASSERT_SVH
`define VIDEO_FRAME_SLICE_PACKETIZER_TOP_ASSERT_SVH

// Property holds at every rising clock edge outside reset.
`define VFSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define VFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vfsp_pkg.sv
// Shared constants and types for the video frame slice packetizer.
// No dependencies.
`default_nettype none

package vfsp_pkg;

    localparam int SLICE_PAYLOAD_BYTES = 1394;
    localparam int MAX_SLICES          = 255;
    localparam int LENGTH_BITS         = 24;
    localparam int SEQ_BITS            = 32;
    localparam int SLICE_OFS_BITS      = 16;
    localparam int COUNT_BITS          = 8;

    localparam int D_BITS      = $clog2(SLICE_PAYLOAD_BYTES + 1);
    localparam int X_BITS      = 8 + D_BITS;
    localparam int RECIP_SHIFT = 8 + 2 * D_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT - D_BITS + 2;
    localparam int PROD_BITS   = X_BITS + RECIP_BITS;
    localparam int CMP_BITS    = (LENGTH_BITS > X_BITS) ? LENGTH_BITS : X_BITS;

    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(SLICE_PAYLOAD_BYTES) - 64'd1) /
        64'(SLICE_PAYLOAD_BYTES);
    localparam longint unsigned CAP_LENGTH =
        64'(MAX_SLICES) * 64'(SLICE_PAYLOAD_BYTES);

    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]            data_byte;
        logic                  pend;
        logic                  hdr;
        logic [SEQ_BITS-1:0]   seq;
        logic [COUNT_BITS-1:0] index;
        logic [COUNT_BITS-1:0] total;
    } slice_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/vfsp_queue.sv
// Short item queue between the classifier and the packet emitter.
// Depends on vfsp_pkg for the item type and depth.
`default_nettype none

module vfsp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  vfsp_pkg::slice_item_t     push_item,
    input  wire logic                 pop,
    output vfsp_pkg::slice_item_t     head,
    output logic                      full,
    output logic                      empty
);

    vfsp_pkg::slice_item_t mem [vfsp_pkg::QUEUE_DEPTH];

    logic [vfsp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vfsp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vfsp_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;

    localparam logic [vfsp_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
        vfsp_pkg::QUEUE_PTR_BITS'(vfsp_pkg::QUEUE_DEPTH - 1);
    localparam logic [vfsp_pkg::QUEUE_CNT_BITS-1:0] FULL_COUNT =
        vfsp_pkg::QUEUE_CNT_BITS'(vfsp_pkg::QUEUE_DEPTH);

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vfsp_front.sv
// Front end: accepts payload bytes, tracks frame and slice position, classifies each item.
// Depends on vfsp_pkg for constants and the queue item type.
`default_nettype none

module vfsp_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [7:0]                        data_byte,
    input  wire logic [vfsp_pkg::LENGTH_BITS-1:0]  frame_length,
    input  wire logic                              q_full,
    output logic                                   in_stall,
    output logic                                   push,
    output vfsp_pkg::slice_item_t                  push_item
);

    localparam int LB = vfsp_pkg::LENGTH_BITS;
    localparam int CB = vfsp_pkg::COUNT_BITS;
    localparam int SB = vfsp_pkg::SLICE_OFS_BITS;

    logic [vfsp_pkg::SEQ_BITS-1:0] seq_reg, seq_next;
    logic [LB-1:0]                 fbo_reg, fbo_next;
    logic [SB-1:0]                 sbo_reg, sbo_next;
    logic [CB-1:0]                 sidx_reg, sidx_next;
    logic [CB-1:0]                 stot_reg, stot_next;

    logic                               accept;
    logic                               first;
    logic                               last;
    logic                               emit;
    logic                               pend;
    logic [vfsp_pkg::CMP_BITS-1:0]      len_wide;
    logic [vfsp_pkg::X_BITS-1:0]        div_x;
    logic [vfsp_pkg::PROD_BITS-1:0]     div_prod;
    logic [CB-1:0]                      div_q;
    logic [CB-1:0]                      tot_eff;
    logic [CB-1:0]                      idx_eff;
    logic [SB-1:0]                      sbo_eff;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall && (frame_length != '0);
    assign first    = (fbo_reg == '0);

    // Ceiling division by the slice payload size through a reciprocal multiply.
    assign len_wide = vfsp_pkg::CMP_BITS'(frame_length);
    assign div_x    = vfsp_pkg::X_BITS'(frame_length) +
                      vfsp_pkg::X_BITS'(vfsp_pkg::SLICE_PAYLOAD_BYTES - 1);
    assign div_prod = vfsp_pkg::PROD_BITS'(div_x) *
                      vfsp_pkg::PROD_BITS'(vfsp_pkg::RECIP);
    assign div_q    = CB'(div_prod >> vfsp_pkg::RECIP_SHIFT);

    always_comb
    begin
        if (len_wide > vfsp_pkg::CMP_BITS'(vfsp_pkg::CAP_LENGTH))
        begin
            tot_eff = CB'(vfsp_pkg::MAX_SLICES);
        end
        else if (first)
        begin
            tot_eff = div_q;
        end
        else
        begin
            tot_eff = stot_reg;
        end
        if (!first)
        begin
            tot_eff = stot_reg;
        end
    end

    assign idx_eff = first ? '0 : sidx_reg;
    assign sbo_eff = first ? '0 : sbo_reg;
    assign last    = ({1'b0, fbo_reg} + (LB + 1)'(1)) >= {1'b0, frame_length};
    assign emit    = (idx_eff < tot_eff);
    assign pend    = last ||
                     (({1'b0, sbo_eff} + (SB + 1)'(1)) >=
                      (SB + 1)'(vfsp_pkg::SLICE_PAYLOAD_BYTES));

    assign push                = accept && emit;
    assign push_item.data_byte = data_byte;
    assign push_item.pend      = pend;
    assign push_item.hdr       = (sbo_eff == '0);
    assign push_item.seq       = seq_reg;
    assign push_item.index     = idx_eff;
    assign push_item.total     = tot_eff;

    always_comb
    begin
        seq_next  = seq_reg;
        fbo_next  = fbo_reg;
        sbo_next  = sbo_reg;
        sidx_next = sidx_reg;
        stot_next = stot_reg;
        if (accept)
        begin
            stot_next = tot_eff;
            sidx_next = idx_eff;
            sbo_next  = sbo_eff;
            if (emit)
            begin
                if (pend)
                begin
                    sbo_next  = '0;
                    sidx_next = idx_eff + 1'b1;
                end
                else
                begin
                    sbo_next = sbo_eff + 1'b1;
                end
            end
            if (last)
            begin
                fbo_next  = '0;
                seq_next  = seq_reg + 1'b1;
                sbo_next  = '0;
                sidx_next = '0;
                stot_next = '0;
            end
            else
            begin
                fbo_next = fbo_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            fbo_reg  <= '0;
            sbo_reg  <= '0;
            sidx_reg <= '0;
            stot_reg <= '0;
        end
        else
        begin
            seq_reg  <= seq_next;
            fbo_reg  <= fbo_next;
            sbo_reg  <= sbo_next;
            sidx_reg <= sidx_next;
            stot_reg <= stot_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vfsp_back.sv
// Back end: expands each queued item into an optional six-byte header and its payload byte.
// Depends on vfsp_pkg for the queue item type.
`default_nettype none

module vfsp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  vfsp_pkg::slice_item_t  head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   packet_end,
    output logic                   run_last
);

    typedef enum logic [6:0] {
        PHASE_SEQ_3 = 7'b0000001,
        PHASE_SEQ_2 = 7'b0000010,
        PHASE_SEQ_1 = 7'b0000100,
        PHASE_SEQ_0 = 7'b0001000,
        PHASE_INDEX = 7'b0010000,
        PHASE_TOTAL = 7'b0100000,
        PHASE_DATA  = 7'b1000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    phase_t     cur_phase;
    logic       taken;

    assign out_valid = !empty;
    assign taken     = out_valid && !out_stall;
    assign cur_phase = head.hdr ? phase_reg : PHASE_DATA;
    assign pop       = taken && (cur_phase == PHASE_DATA);
    assign run_last  = (cur_phase == PHASE_DATA);
    assign packet_end = (cur_phase == PHASE_DATA) && head.pend;

    always_comb
    begin
        case (cur_phase)
            PHASE_SEQ_3: out_byte = head.seq[31:24];
            PHASE_SEQ_2: out_byte = head.seq[23:16];
            PHASE_SEQ_1: out_byte = head.seq[15:8];
            PHASE_SEQ_0: out_byte = head.seq[7:0];
            PHASE_INDEX: out_byte = head.index;
            PHASE_TOTAL: out_byte = head.total;
            default:     out_byte = head.data_byte;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (taken)
        begin
            case (cur_phase)
                PHASE_SEQ_3: phase_next = PHASE_SEQ_2;
                PHASE_SEQ_2: phase_next = PHASE_SEQ_1;
                PHASE_SEQ_1: phase_next = PHASE_SEQ_0;
                PHASE_SEQ_0: phase_next = PHASE_INDEX;
                PHASE_INDEX: phase_next = PHASE_TOTAL;
                PHASE_TOTAL: phase_next = PHASE_DATA;
                default:     phase_next = PHASE_SEQ_3;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_SEQ_3;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/video_frame_slice_packetizer_top.sv
// The first output byte of an item is shown in the cycle after the item is accepted
// when the queue is empty, later while earlier items still wait in the queue.
// Throughput: one input byte per cycle; the emitter sends one byte per cycle unless stalled,
// each slice start adds six header bytes, and the four-entry queue stalls input while full.
// Reset: rst_n clears the sequence number, frame and slice counters and the queue at once.
// Depends on vfsp_pkg, vfsp_front, vfsp_queue and vfsp_back.
`default_nettype none

module video_frame_slice_packetizer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              frame_valid,
    output logic                                   frame_stall,
    input  wire logic [7:0]                        data_byte,
    input  wire logic [vfsp_pkg::LENGTH_BITS-1:0]  frame_length,
    output logic                                   packet_valid,
    input  wire logic                              packet_stall,
    output logic [7:0]                             out_byte,
    output logic                                   packet_end,
    output logic                                   run_last
);

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    vfsp_pkg::slice_item_t push_item;
    vfsp_pkg::slice_item_t head;

    vfsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (frame_valid),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .q_full       (q_full),
        .in_stall     (frame_stall),
        .push         (q_push),
        .push_item    (push_item)
    );

    vfsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    vfsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (q_pop),
        .out_valid  (packet_valid),
        .out_stall  (packet_stall),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/vfsp_checker.sv
// Port-level checks for the video frame slice packetizer, bound to the top level.
// Depends on vfsp_pkg and video_frame_slice_packetizer_top_assert.svh.
`default_nettype none

`include "video_frame_slice_packetizer_top_assert.svh"

module vfsp_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              frame_valid,
    input wire logic                              frame_stall,
    input wire logic [7:0]                        data_byte,
    input wire logic [vfsp_pkg::LENGTH_BITS-1:0]  frame_length,
    input wire logic                              packet_valid,
    input wire logic                              packet_stall,
    input wire logic [7:0]                        out_byte,
    input wire logic                              packet_end,
    input wire logic                              run_last
);

    `VFSP_ASSERT(a_end_is_last, !(packet_valid && packet_end) || run_last,
        "packet end without run last")
    `VFSP_ASSERT(a_stall_needs_backlog, !frame_stall || packet_valid,
        "input stalled with nothing pending")
    `VFSP_ASSERT_NEXT(a_header_continues, packet_valid && !packet_stall && !run_last,
        packet_valid, "header run broken")
    `VFSP_ASSERT_NEXT(a_stalled_hold, packet_valid && packet_stall,
        packet_valid && $stable(out_byte) && $stable(packet_end) && $stable(run_last),
        "stalled result changed")
    `VFSP_ASSERT_NEXT(a_input_hold, frame_valid && frame_stall,
        frame_valid && $stable(data_byte) && $stable(frame_length),
        "stalled input item changed")

endmodule

bind video_frame_slice_packetizer_top vfsp_checker u_vfsp_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for video_frame_slice_packetizer_top: drives payload bytes with
// frame lengths and checks every slice header and payload byte against a built-in predictor.
// Depends on vfsp_pkg and the packetizer RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       pend;
        logic       last;
    } slice_byte_t;

    class slice_scoreboard;
        logic [31:0]                      seq_num;
        logic [vfsp_pkg::LENGTH_BITS-1:0] frame_pos;
        logic [15:0]                      slice_pos;
        logic [7:0]                       slice_num;
        logic [7:0]                       slice_count;
        slice_byte_t                      bytes_due[$];
        int                               errors;

        function new();
            seq_num     = '0;
            frame_pos   = '0;
            slice_pos   = '0;
            slice_num   = '0;
            slice_count = '0;
            errors      = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return bytes_due.size();
        endfunction

        function void queue_byte(input logic [7:0] value, input logic pend, input logic last);
            slice_byte_t b;
            b.value = value;
            b.pend  = pend;
            b.last  = last;
            bytes_due.push_back(b);
        endfunction

        function void note_input(input logic [7:0] value,
                                 input logic [vfsp_pkg::LENGTH_BITS-1:0] len);
            int unsigned count;
            logic        frame_done;
            logic        slice_done;
            if (len == 0)
                return;
            if (frame_pos == 0)
            begin
                count = (32'(len) + vfsp_pkg::SLICE_PAYLOAD_BYTES - 1) /
                        vfsp_pkg::SLICE_PAYLOAD_BYTES;
                if (count > vfsp_pkg::MAX_SLICES)
                    count = vfsp_pkg::MAX_SLICES;
                slice_count = count[7:0];
                slice_num   = '0;
                slice_pos   = '0;
            end
            frame_done = (33'(frame_pos) + 1) >= 33'(len);
            if (slice_num < slice_count)
            begin
                if (slice_pos == 0)
                begin
                    queue_byte(seq_num[31:24], 1'b0, 1'b0);
                    queue_byte(seq_num[23:16], 1'b0, 1'b0);
                    queue_byte(seq_num[15:8], 1'b0, 1'b0);
                    queue_byte(seq_num[7:0], 1'b0, 1'b0);
                    queue_byte(slice_num, 1'b0, 1'b0);
                    queue_byte(slice_count, 1'b0, 1'b0);
                end
                slice_done = frame_done ||
                             ((32'(slice_pos) + 1) >= vfsp_pkg::SLICE_PAYLOAD_BYTES);
                queue_byte(value, slice_done, 1'b1);
                if (slice_done)
                begin
                    slice_pos = '0;
                    slice_num = slice_num + 8'd1;
                end
                else
                begin
                    slice_pos = slice_pos + 16'd1;
                end
            end
            if (frame_done)
            begin
                frame_pos   = '0;
                seq_num     = seq_num + 32'd1;
                slice_pos   = '0;
                slice_num   = '0;
                slice_count = '0;
            end
            else
            begin
                frame_pos = frame_pos + 1'b1;
            end
        endfunction

        task check_result(input logic [7:0] value, input logic pend, input logic last);
            slice_byte_t want;
            if (bytes_due.size() == 0)
            begin
                report($sformatf("unexpected output byte %02h", value));
                return;
            end
            want = bytes_due.pop_front();
            if (value !== want.value)
                report($sformatf("out_byte %02h, want %02h", value, want.value));
            if (pend !== want.pend)
                report($sformatf("packet_end %b, want %b", pend, want.pend));
            if (last !== want.last)
                report($sformatf("run_last %b, want %b", last, want.last));
        endtask
    endclass

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             frame_valid  = 1'b0;
    logic [7:0]                       data_byte    = '0;
    logic [vfsp_pkg::LENGTH_BITS-1:0] frame_length = '0;
    logic                             packet_stall = 1'b0;
    logic                             frame_stall;
    logic                             packet_valid;
    logic [7:0]                       out_byte;
    logic                             packet_end;
    logic                             run_last;

    slice_scoreboard sb;
    int              idle_pct   = 15;
    int              stall_pct  = 15;
    int              items_sent = 0;

    video_frame_slice_packetizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .packet_valid (packet_valid),
        .packet_stall (packet_stall),
        .out_byte     (out_byte),
        .packet_end   (packet_end),
        .run_last     (run_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        packet_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
                sb.note_input(data_byte, frame_length);
            if (packet_valid && !packet_stall)
                sb.check_result(out_byte, packet_end, run_last);
        end
    end

    task automatic send_item(input logic [7:0] value,
                             input logic [vfsp_pkg::LENGTH_BITS-1:0] len);
        while ($urandom_range(99) < idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid  <= 1'b1;
        data_byte    <= value;
        frame_length <= len;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        if (len != 0)
            items_sent++;
    endtask

    task automatic send_frame(input int len);
        for (int k = 0; k < len; k++)
            send_item(8'($urandom_range(255)), vfsp_pkg::LENGTH_BITS'(len));
    endtask

    // The first item fixes the slice total; the rest carry a new length until it ends the frame.
    task automatic send_split_frame(input int unsigned first_len, input int unsigned rest_len);
        int unsigned pos;
        send_item(8'($urandom_range(255)), vfsp_pkg::LENGTH_BITS'(first_len));
        pos = 1;
        do
        begin
            send_item(8'($urandom_range(255)), vfsp_pkg::LENGTH_BITS'(rest_len));
            pos++;
        end
        while (pos < rest_len);
    endtask

    task automatic send_shifting_frame();
        int                               n;
        logic [vfsp_pkg::LENGTH_BITS-1:0] len;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
        begin
            if (k == n - 1)
                len = vfsp_pkg::LENGTH_BITS'($urandom_range(1, k + 1));
            else
                len = vfsp_pkg::LENGTH_BITS'($urandom_range(k + 2, 32'hFF_FFFF));
            send_item(8'($urandom_range(255)), len);
        end
    endtask

    task automatic send_noisy_frame();
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(3) == 0)
                send_item(8'($urandom_range(255)), '0);
            send_item(8'($urandom_range(255)), vfsp_pkg::LENGTH_BITS'(len));
        end
    endtask

    initial
    begin
        int first_len;
        int pick;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(8'h00, 1);
        send_item(8'hFF, 1);
        send_item(8'h5A, '0);
        send_item(8'h00, 3);
        send_item(8'hAA, '0);
        send_item(8'h55, 3);
        send_item(8'hFF, 3);
        send_split_frame(32'hFF_FFFF, 2);
        send_split_frame(vfsp_pkg::MAX_SLICES * vfsp_pkg::SLICE_PAYLOAD_BYTES, 1);
        send_split_frame(vfsp_pkg::MAX_SLICES * vfsp_pkg::SLICE_PAYLOAD_BYTES + 1, 2);
        send_split_frame(vfsp_pkg::SLICE_PAYLOAD_BYTES, 2);
        send_split_frame(vfsp_pkg::SLICE_PAYLOAD_BYTES + 1, 2);
        send_split_frame(32'h80_0000, 1);

        idle_pct  = 0;
        stall_pct = 0;
        send_split_frame(vfsp_pkg::SLICE_PAYLOAD_BYTES, vfsp_pkg::SLICE_PAYLOAD_BYTES + 6);
        idle_pct  = 15;
        stall_pct = 15;
        send_frame(vfsp_pkg::SLICE_PAYLOAD_BYTES + 2);

        items_sent = 0;
        while (items_sent < 450)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_frame($urandom_range(1, 12));
            end
            else if (pick < 75)
            begin
                send_shifting_frame();
            end
            else if (pick < 88)
            begin
                send_noisy_frame();
            end
            else
            begin
                first_len = $urandom_range(2, 4);
                send_split_frame(first_len, first_len + $urandom_range(1, 8));
            end
        end
        frame_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/vfsp_pkg.sv
hw/rtl/vfsp_queue.sv
hw/rtl/vfsp_front.sv
hw/rtl/vfsp_back.sv
hw/rtl/video_frame_slice_packetizer_top.sv
hw/rtl/vfsp_checker.sv
tb/testbench.sv
